@@ rtl/core/fcad_pkg.sv @@
// fcad_pkg: shared constants and beat types for the fire cell averaging block.
// No dependencies; imported by fcad_window and fire_cell_average_decay.
`timescale 1ns / 1ps
`default_nettype none

package fcad_pkg;

  // Flame buffer geometry
  localparam int unsigned ROW_WIDTH   = 320;
  localparam int unsigned ROW_COUNT   = 50;
  localparam int unsigned DECAY_ROW   = 46;
  localparam int unsigned FRAME_CELLS = ROW_WIDTH * ROW_COUNT;

  // Widths
  localparam int unsigned POS_W      = $clog2(FRAME_CELLS);
  localparam int unsigned COL_W      = $clog2(ROW_WIDTH);
  localparam int unsigned LAG_W      = $clog2(ROW_WIDTH - 1);
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned CELL_POS_W = 14;
  localparam int unsigned SUM_W      = CELL_W + 3;

  // First input position that completes a neighborhood
  localparam int unsigned PRODUCE_START = 2 * ROW_WIDTH + 2;
  // Input position whose centre cell is the first cell of the decay row
  localparam int unsigned DECAY_START   = DECAY_ROW * ROW_WIDTH + ROW_WIDTH + 1;
  // Centre cell produced by the last input position of a frame
  localparam int unsigned LAST_CENTRE   = FRAME_CELLS - ROW_WIDTH - 2;

  localparam logic [CELL_W-1:0] BASE_COLOR_RESET = 8'd64;
  localparam logic [CELL_W-1:0] COLOR_SPAN       = 8'd15;

  typedef struct packed {
    logic [CELL_W-1:0] cell_in;
    logic              frame_start;
  } fcad_in_t;

  typedef struct packed {
    logic [CELL_W-1:0]     cell_out;
    logic [CELL_W-1:0]     shaded_color;
    logic [CELL_POS_W-1:0] cell_position;
    logic                  frame_last;
  } fcad_out_t;

  // The eight neighbors of the centre cell, named by their age in beats
  typedef struct packed {
    logic [CELL_W-1:0] age_0;
    logic [CELL_W-1:0] age_1;
    logic [CELL_W-1:0] age_2;
    logic [CELL_W-1:0] age_w;
    logic [CELL_W-1:0] age_w2;
    logic [CELL_W-1:0] age_2w;
    logic [CELL_W-1:0] age_2w1;
    logic [CELL_W-1:0] age_2w2;
  } fcad_taps_t;

endpackage

`default_nettype wire

@@ rtl/core/fcad_window.sv @@
// fcad_window: two line memories plus tap registers holding the neighbor window.
// Depends on fcad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcad_window
  import fcad_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift_en,
  input  wire logic [CELL_W-1:0] shift_byte,
  output fcad_taps_t             taps
);

  // Line memories: mem_a delays by ROW_WIDTH beats, mem_b by ROW_WIDTH-1 more
  logic [CELL_W-1:0] mem_a [ROW_WIDTH];
  logic [CELL_W-1:0] mem_b [ROW_WIDTH-1];

  logic [COL_W-1:0]  ptr_a_r;
  logic [COL_W-1:0]  ptr_a_nxt;
  logic [LAG_W-1:0]  ptr_b_r;
  logic [LAG_W-1:0]  ptr_b_nxt;

  logic [CELL_W-1:0] rd_a_r;
  logic [CELL_W-1:0] rd_b_r;
  logic [CELL_W-1:0] h0_r, h1_r, h2_r;
  logic [CELL_W-1:0] a1_r, a2_r;
  logic [CELL_W-1:0] b1_r, b2_r;

  // Circular pointers, advanced once per beat
  assign ptr_a_nxt = (ptr_a_r == COL_W'(ROW_WIDTH - 1)) ? '0 : ptr_a_r + COL_W'(1);
  assign ptr_b_nxt = (ptr_b_r == LAG_W'(ROW_WIDTH - 2)) ? '0 : ptr_b_r + LAG_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_a_r <= '0;
      ptr_b_r <= '0;
    end else if (shift_en) begin
      ptr_a_r <= ptr_a_nxt;
      ptr_b_r <= ptr_b_nxt;
    end
  end

  // Read old data then write the same entry: read-before-write covers the overlap
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rd_a_r         <= mem_a[ptr_a_r];
      mem_a[ptr_a_r] <= shift_byte;
    end
  end

  // mem_b is fed with the previous beat's mem_a output
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rd_b_r         <= mem_b[ptr_b_r];
      mem_b[ptr_b_r] <= rd_a_r;
    end
  end

  // Short delays around each memory tap
  always_ff @(posedge clk) begin
    if (shift_en) begin
      h0_r <= shift_byte;
      h1_r <= h0_r;
      h2_r <= h1_r;
      a1_r <= rd_a_r;
      a2_r <= a1_r;
      b1_r <= rd_b_r;
      b2_r <= b1_r;
    end
  end

  assign taps.age_0   = h0_r;
  assign taps.age_1   = h1_r;
  assign taps.age_2   = h2_r;
  assign taps.age_w   = rd_a_r;
  assign taps.age_w2  = a2_r;
  assign taps.age_2w  = rd_b_r;
  assign taps.age_2w1 = b1_r;
  assign taps.age_2w2 = b2_r;

endmodule

`default_nettype wire

@@ rtl/core/fire_cell_average_decay.sv @@
// fire_cell_average_decay: streaming next-generation step of a flame buffer.
// Depends on fcad_pkg and fcad_window.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | handshake         | beat
//  ---------+-----------+-------------------+---------------------------------
//  in_      | input     | in_valid/in_stall | fcad_in_t: one cell byte
//  out_     | output    | out_valid/out_stall | fcad_out_t: one new cell
//  cfg_     | input     | cfg_we            | base_color, 8 bits
//
//  One beat per clock sustained while in_stall is low.
//  Throughput is set by the single read/write port of each line memory.
//  Reset clears position, pointers and valids; line memories are not cleared.
//  A one-entry skid buffer absorbs a stall; in_stall follows the skid state.

module fire_cell_average_decay
  import fcad_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire fcad_in_t          in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      fcad_out_t         out_data,
  input  wire logic              cfg_we,
  input  wire logic [CELL_W-1:0] cfg_wdata
);

  logic              en;
  logic              in_accept;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [POS_W-1:0]  p_cur;
  logic [CELL_W-1:0] base_color_r;
  fcad_taps_t        taps;

  logic              s2_valid_r;
  logic [POS_W-1:0]  s2_centre_r;
  logic              s2_decay_r;
  logic              s2_last_r;

  logic              s3_valid_r;
  logic [SUM_W-1:0]  s3_sum_r;
  logic [POS_W-1:0]  s3_centre_r;
  logic              s3_decay_r;
  logic              s3_last_r;

  logic [SUM_W-1:0]  sum_nxt;
  logic [CELL_W-1:0] v_avg;
  logic [CELL_W-1:0] v_nxt;
  logic [CELL_W-1:0] t_raw;
  logic [CELL_W-1:0] t_cap;
  fcad_out_t         res_nxt;

  fcad_out_t         out_data_r;
  logic              out_valid_r;
  fcad_out_t         skid_data_r;
  logic              skid_valid_r;

  // Pipeline moves whenever the skid entry is free
  assign en        = !skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_color_r <= BASE_COLOR_RESET;
    end else if (cfg_we) begin
      base_color_r <= cfg_wdata;
    end
  end

  // Input position: frame_start forces zero, wraps at frame end
  assign p_cur   = in_data.frame_start ? '0 : pos_r;
  assign pos_nxt = (32'(p_cur) + 32'd1 >= FRAME_CELLS) ? '0 : p_cur + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_accept) begin
      pos_r <= pos_nxt;
    end
  end

  fcad_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (in_accept),
    .shift_byte (in_data.cell_in),
    .taps       (taps)
  );

  // Stage 2: per-beat control, taps settle in the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= in_accept && (32'(p_cur) >= PRODUCE_START);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_centre_r <= p_cur - POS_W'(ROW_WIDTH + 1);
      s2_decay_r  <= 32'(p_cur) >= DECAY_START;
      s2_last_r   <= 32'(p_cur) == FRAME_CELLS - 1;
    end
  end

  // Stage 3: neighbor sum
  assign sum_nxt = SUM_W'(taps.age_0) + SUM_W'(taps.age_1) + SUM_W'(taps.age_2)
                 + SUM_W'(taps.age_w) + SUM_W'(taps.age_w2)
                 + SUM_W'(taps.age_2w) + SUM_W'(taps.age_2w1) + SUM_W'(taps.age_2w2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r    <= sum_nxt;
      s3_centre_r <= s2_centre_r;
      s3_decay_r  <= s2_decay_r;
      s3_last_r   <= s2_last_r;
    end
  end

  // Average, decay and palette shading
  assign v_avg = s3_sum_r[SUM_W-1:3];

  always_comb begin
    v_nxt = v_avg;
    if (s3_sum_r[1:0] == 2'b00) begin
      if (s3_decay_r || (v_avg != '0)) begin
        v_nxt = v_avg - CELL_W'(1);
      end
    end
  end

  assign t_raw = {1'b0, v_nxt[CELL_W-1:1]} + base_color_r;
  assign t_cap = base_color_r + COLOR_SPAN;

  assign res_nxt.cell_out      = v_nxt;
  assign res_nxt.shaded_color  = (t_raw > t_cap) ? t_cap : t_raw;
  assign res_nxt.cell_position = CELL_POS_W'(s3_centre_r);
  assign res_nxt.frame_last    = s3_last_r;

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_r <= 1'b0;
      end
    end else if (s3_valid_r) begin
      if (out_valid_r && out_stall) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_data_r <= skid_data_r;
      end
    end else if (s3_valid_r) begin
      if (out_valid_r && out_stall) begin
        skid_data_r <= res_nxt;
      end else begin
        out_data_r <= res_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid entry is only ever filled behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full without a held output beat");

  // A result meeting a stalled output must land in the skid entry
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !skid_valid_r && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("result lost against a stalled output");

  // Frame start restarts the position count
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.frame_start) |=> (pos_r == POS_W'(1)))
    else $error("position did not restart on frame start");

  // The last beat of a frame always carries the final produced cell
  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_last)
      |-> (out_data_r.cell_position == CELL_POS_W'(LAST_CENTRE)))
    else $error("frame_last on a wrong cell position");

endmodule

`default_nettype wire

@@ sim/tb_fire_cell_average_decay.sv @@
// tb_fire_cell_average_decay: self-checking testbench for the flame buffer step.
// Depends on fcad_pkg and fire_cell_average_decay; predicts every new cell and
// checks each out_ beat in order against that prediction.
`timescale 1ns / 1ps

module tb_fire_cell_average_decay;
  import fcad_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum int {FILL_ZERO, FILL_FULL, FILL_LOW, FILL_QUAD, FILL_RAND} fill_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  fcad_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  fcad_out_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CELL_W-1:0] cfg_wdata = '0;

  // Pending input beats and predicted new cells
  fcad_in_t  cell_beat_q[$];
  fcad_out_t new_cell_q[$];

  // Predictor state
  logic [CELL_W-1:0] frame_bytes [FRAME_CELLS];
  int unsigned       in_pos     = 0;
  logic [CELL_W-1:0] base_model = BASE_COLOR_RESET;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  fcad_out_t   want;

  fire_cell_average_decay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Store one accepted byte and predict the new cell it completes, if any
  task automatic advance_flame(input fcad_in_t b);
    int unsigned       p;
    int unsigned       ctr;
    logic [SUM_W-1:0]  sum;
    logic [CELL_W-1:0] v;
    logic [CELL_W-1:0] t;
    logic [CELL_W-1:0] cap;
    fcad_out_t         r;
    if (b.frame_start) in_pos = 0;
    p = in_pos;
    frame_bytes[p] = b.cell_in;
    in_pos = (p + 1 >= FRAME_CELLS) ? 0 : p + 1;
    if (p >= PRODUCE_START) begin
      ctr = p - ROW_WIDTH - 1;
      sum = frame_bytes[ctr - ROW_WIDTH - 1] + frame_bytes[ctr - ROW_WIDTH]
          + frame_bytes[ctr - ROW_WIDTH + 1] + frame_bytes[ctr - 1]
          + frame_bytes[ctr + 1] + frame_bytes[ctr + ROW_WIDTH - 1]
          + frame_bytes[ctr + ROW_WIDTH] + frame_bytes[ctr + ROW_WIDTH + 1];
      v = sum[SUM_W-1:3];
      // Decay: wraps from the decay row down, saturates at zero above it
      if (sum[1:0] == 2'b00) begin
        if (ctr >= DECAY_ROW * ROW_WIDTH) v = v - 1'b1;
        else if (v != '0) v = v - 1'b1;
      end
      t   = {1'b0, v[CELL_W-1:1]} + base_model;
      cap = base_model + COLOR_SPAN;
      if (t > cap) t = cap;
      r.cell_out      = v;
      r.shaded_color  = t;
      r.cell_position = ctr[CELL_POS_W-1:0];
      r.frame_last    = (p == FRAME_CELLS - 1);
      new_cell_q.push_back(r);
    end
  endtask

  // Driver: predict on acceptance, then load the next beat or idle
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) advance_flame(in_data);
    if (!in_valid || !in_stall) begin
      if (cell_beat_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= cell_beat_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (new_cell_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected beat cell %0d color %0d pos %0d last %0b", $time,
                   out_data.cell_out, out_data.shaded_color, out_data.cell_position,
                   out_data.frame_last);
      end else begin
        want = new_cell_q.pop_front();
        if (out_data.cell_out !== want.cell_out ||
            out_data.shaded_color !== want.shaded_color ||
            out_data.cell_position !== want.cell_position ||
            out_data.frame_last !== want.frame_last) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("%0t: expected cell %0d color %0d pos %0d last %0b, got %0d %0d %0d %0b",
                     $time, want.cell_out, want.shaded_color, want.cell_position,
                     want.frame_last, out_data.cell_out, out_data.shaded_color,
                     out_data.cell_position, out_data.frame_last);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic logic [CELL_W-1:0] fill_byte(input fill_e mode);
    logic [CELL_W-1:0] r;
    r = CELL_W'($urandom);
    case (mode)
      FILL_ZERO: return '0;
      FILL_FULL: return '1;
      FILL_LOW:  return CELL_W'($urandom_range(0, 3));
      FILL_QUAD: return {r[CELL_W-1:2], 2'b00};
      default:   return r;
    endcase
  endfunction

  // One frame run; mixed runs switch fill style in random segments
  task automatic queue_frame(input int unsigned len, input bit mark_start,
                             input bit mixed, input fill_e mode);
    int unsigned seg_left;
    fill_e       cur;
    fcad_in_t    b;
    seg_left = 0;
    cur      = mode;
    for (int unsigned i = 0; i < len; i++) begin
      if (mixed && seg_left == 0) begin
        cur      = fill_e'($urandom_range(FILL_ZERO, FILL_RAND));
        seg_left = $urandom_range(1, 400);
      end
      if (seg_left > 0) seg_left--;
      b.cell_in     = fill_byte(cur);
      b.frame_start = mark_start && (i == 0);
      cell_beat_q.push_back(b);
    end
  endtask

  // Random bytes with frequent frame restarts
  task automatic queue_noise(input int unsigned len);
    fcad_in_t b;
    for (int unsigned i = 0; i < len; i++) begin
      b.cell_in     = CELL_W'($urandom);
      b.frame_start = ($urandom_range(0, 3) == 0);
      cell_beat_q.push_back(b);
    end
  endtask

  // Wait until every beat is taken and every new cell has come out
  task automatic drain();
    do @(posedge clk); while (cell_beat_q.size() > 0 || in_valid);
    while (new_cell_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(input logic [CELL_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_model = value;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles a little, receiver stalls half the time; reset base color.
    // A short noise burst, then one frame that starts all zero and runs on
    send_idle_pct = 12;
    recv_idle_pct = 50;
    queue_noise(3);
    queue_frame(PRODUCE_START + 40, 1'b1, 1'b0, FILL_ZERO);
    queue_frame(100, 1'b0, 1'b1, FILL_RAND);
    drain();

    // The same frame runs on; base 255 makes the color cap wrap
    send_idle_pct = 50;
    recv_idle_pct = 12;
    write_base(8'd255);
    queue_frame(250, 1'b0, 1'b1, FILL_RAND);
    drain();

    // No idling; cap of exactly zero, then base zero on saturated cells,
    // then a random base and a burst of frame restarts
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_base(8'd241);
    queue_frame(150, 1'b0, 1'b1, FILL_RAND);
    drain();
    write_base(8'd0);
    queue_frame(120, 1'b0, 1'b0, FILL_FULL);
    drain();
    write_base(CELL_W'($urandom_range(0, 255)));
    queue_frame(120, 1'b0, 1'b1, FILL_RAND);
    queue_noise(20);
    drain();

    if (mismatches == 0 && new_cell_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
